[hw/rtl/utfc_pkg.sv]
// Shared types, constants and helpers of the UTF-8 text feature counter.
// No dependencies; every module of the block imports this package.
package utfc_pkg;

   // Counter and fixed-point sizes
   localparam int COUNT_WIDTH    = 24;
   localparam int FRAC_BITS      = 16;
   localparam int MARK_WIDTH     = 5;
   localparam int NUM_MARKS      = 7;
   localparam int NUM_FEATURES   = 14;
   localparam int FEAT_WIDTH     = 4;
   localparam int CAP_WIDTH      = 16;
   localparam int CODE_WIDTH     = 21;
   localparam int BYTE_WIDTH     = 8;
   localparam int ERR_WIDTH      = 2;
   localparam int VALUE_WIDTH    = 32;
   localparam int NAME_CAP       = 512;
   localparam int TOKEN_WIDTH    = 16;

   // Log and divide unit sizes
   localparam int LOG_IN_WIDTH   = 10;
   localparam int LOG_FRAC       = 28;
   localparam int LOG_EXP_WIDTH  = 4;
   localparam int LOG_RES_WIDTH  = LOG_EXP_WIDTH + LOG_FRAC;
   localparam int LOG_STEP_WIDTH = 5;
   localparam int DIV_NUM_WIDTH  = 64;
   localparam int DIV_DEN_WIDTH  = 32;
   localparam int DIV_STEP_WIDTH = 6;
   localparam int QUOT_SHIFT     = 30;
   localparam int RNUM_WIDTH     = (COUNT_WIDTH > TOKEN_WIDTH) ? COUNT_WIDTH : TOKEN_WIDTH;

   // Register map
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_TOKEN_CAP = 1'b0;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(256);

   // Error codes
   localparam logic [ERR_WIDTH-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_WIDTH-1:0] ERR_LEAD  = 2'd1;
   localparam logic [ERR_WIDTH-1:0] ERR_CONT  = 2'd2;
   localparam logic [ERR_WIDTH-1:0] ERR_TRUNC = 2'd3;

   // Feature positions
   localparam logic [FEAT_WIDTH-1:0] FEAT_TOKEN      = 4'd0;
   localparam logic [FEAT_WIDTH-1:0] FEAT_CHARS      = 4'd1;
   localparam logic [FEAT_WIDTH-1:0] FEAT_TOKEN_RATE = 4'd2;
   localparam logic [FEAT_WIDTH-1:0] FEAT_MARK0      = 4'd3;
   localparam logic [FEAT_WIDTH-1:0] FEAT_KANA       = 4'd10;
   localparam logic [FEAT_WIDTH-1:0] FEAT_KANJI      = 4'd11;
   localparam logic [FEAT_WIDTH-1:0] FEAT_ALNUM      = 4'd12;
   localparam logic [FEAT_WIDTH-1:0] FEAT_SPEAKER    = 4'd13;

   localparam logic [VALUE_WIDTH-1:0] FEAT_ONE = VALUE_WIDTH'(64'd1 << FRAC_BITS);

   typedef enum logic [1:0] {
      FK_RATIO,
      FK_LOG,
      FK_FLAG
   } feat_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FEATURE,
      ST_LOG_DEN,
      ST_LOG_NUM,
      ST_DIVIDE,
      ST_RESULT
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic clear;
      logic log_start;
      logic log_num;
      logic den_latch;
      logic div_start;
      logic out_load;
      logic out_err;
      logic [FEAT_WIDTH-1:0] feat;
   } utfc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic text_bad;
      logic log_done;
      logic div_done;
      logic out_last;
   } utfc_status_type;

   // How each feature is formed
   function automatic feat_kind_type feat_kind(input logic [FEAT_WIDTH-1:0] f);
      feat_kind_type k;
      case (f)
         FEAT_TOKEN, FEAT_TOKEN_RATE, FEAT_KANA, FEAT_KANJI, FEAT_ALNUM: k = FK_RATIO;
         FEAT_SPEAKER: k = FK_FLAG;
         default: k = FK_LOG;
      endcase
      return k;
   endfunction

endpackage

[hw/rtl/utfc_log2.sv]
// Iterative base-2 logarithm, 28 fraction bits, one squaring per cycle.
// Depends on utfc_pkg.
module utfc_log2 import utfc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [LOG_IN_WIDTH-1:0]  x,
   output logic                     done,
   output logic [LOG_RES_WIDTH-1:0] result
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [LOG_STEP_WIDTH-1:0] step_ff, step_in;
   logic [LOG_FRAC:0]         m_ff, m_in;
   logic [LOG_FRAC-1:0]       frac_ff, frac_in;
   logic [LOG_EXP_WIDTH-1:0]  exp_ff, exp_in;
   logic [LOG_EXP_WIDTH-1:0]  lead;
   logic [2*LOG_FRAC+1:0]     sq;
   logic [LOG_FRAC+1:0]       sq_top;

   // Find the leading one of the operand
   always_comb begin
      lead = '0;
      for (int i = 0; i < LOG_IN_WIDTH; i++) begin
         if (x[i]) lead = LOG_EXP_WIDTH'(i);
      end
   end

   assign sq     = m_ff * m_ff;
   assign sq_top = sq[2*LOG_FRAC+1:LOG_FRAC];

   // Normalize on start, then square and renormalize once per fraction bit
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      exp_in  = exp_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         exp_in  = lead;
         frac_in = '0;
         m_in    = (LOG_FRAC+1)'(x) << (LOG_STEP_WIDTH'(LOG_FRAC) - LOG_STEP_WIDTH'(lead));
      end else if (busy_ff) begin
         if (sq_top[LOG_FRAC+1]) begin
            m_in    = sq_top[LOG_FRAC+1:1];
            frac_in = {frac_ff[LOG_FRAC-2:0], 1'b1};
         end else begin
            m_in    = sq_top[LOG_FRAC:0];
            frac_in = {frac_ff[LOG_FRAC-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LOG_STEP_WIDTH'(LOG_FRAC - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      m_ff    <= m_in;
      frac_ff <= frac_in;
      exp_ff  <= exp_in;
   end

   assign done   = done_ff;
   assign result = {exp_ff, frac_ff};

endmodule

[hw/rtl/utfc_divider.sv]
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on utfc_pkg.
module utfc_divider import utfc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIV_NUM_WIDTH-1:0] dividend,
   input  logic [DIV_DEN_WIDTH-1:0] divisor,
   output logic                     done,
   output logic [DIV_NUM_WIDTH-1:0] quotient
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [DIV_STEP_WIDTH-1:0] step_ff, step_in;
   logic [DIV_NUM_WIDTH-1:0]  dvd_ff, dvd_in;
   logic [DIV_DEN_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIV_DEN_WIDTH-1:0]  dvs_ff, dvs_in;
   logic [DIV_DEN_WIDTH:0]    trial;
   logic                      fits;

   assign trial = {rem_ff, dvd_ff[DIV_NUM_WIDTH-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   // Shift in one dividend bit and subtract where the divisor fits
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? DIV_DEN_WIDTH'(trial - {1'b0, dvs_ff}) : trial[DIV_DEN_WIDTH-1:0];
         dvd_in  = {dvd_ff[DIV_NUM_WIDTH-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_WIDTH'(DIV_NUM_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

[hw/rtl/utfc_datapath.sv]
// Datapath: UTF-8 decoder, saturating tallies, operand selection, log and
// divide units and the result register. Depends on utfc_pkg, utfc_log2, utfc_divider.
module utfc_datapath import utfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  utfc_cmd_type         cmd,
   input  logic [31:0]          req_tdata,
   input  logic                 req_tuser,
   input  logic                 req_tlast,
   input  logic [CAP_WIDTH-1:0] token_cap,
   output utfc_status_type      status,
   output logic [39:0]          rsp_tdata,
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   localparam logic [CODE_WIDTH-1:0] EMOJI_SINGLE [51] = '{
      21'h23E9,  21'h1F36D, 21'h1F3AD, 21'h1F3B5, 21'h1F422, 21'h1F431, 21'h1F442,
      21'h1F443, 21'h1F445, 21'h1F44C, 21'h1F44F, 21'h1F48B, 21'h1F4A5, 21'h1F4A6,
      21'h1F4AA, 21'h1F4C4, 21'h1F4DE, 21'h1F4E2, 21'h1F4E3, 21'h1F606, 21'h1F60A,
      21'h1F60C, 21'h1F60E, 21'h1F60F, 21'h1F612, 21'h1F616, 21'h1F61F, 21'h1F620,
      21'h1F62A, 21'h1F62D, 21'h1F62E, 21'h1F630, 21'h1F631, 21'h1F632, 21'h1F634,
      21'h1F644, 21'h1F64F, 21'h1F910, 21'h1F914, 21'h1F922, 21'h1F927, 21'h1F92D,
      21'h1F964, 21'h1F971, 21'h1F974, 21'h1F975, 21'h1F979, 21'h1F97A, 21'h1FAE3,
      21'h1FAF6, 21'h1F4D6
   };
   localparam logic [CODE_WIDTH-1:0] EMOJI_PREFIX [4] = '{
      21'h23F1, 21'h23F8, 21'h1F32C, 21'h1F39B
   };
   localparam logic [2:0] MARK_PERIOD = 3'd0;
   localparam logic [2:0] MARK_COMMA  = 3'd1;
   localparam logic [2:0] MARK_LONG   = 3'd2;
   localparam logic [2:0] MARK_ELLIP  = 3'd3;
   localparam logic [2:0] MARK_EXCL   = 3'd4;
   localparam logic [2:0] MARK_QUEST  = 3'd5;
   localparam logic [2:0] MARK_EMOJI  = 3'd6;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [MARK_WIDTH-1:0] mark_inc(input logic [MARK_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [MARK_WIDTH-1:0] mark_cap(input logic [2:0] sel);
      return (sel == MARK_COMMA) ? MARK_WIDTH'(16) : MARK_WIDTH'(8);
   endfunction

   // Per-text state
   logic [1:0]             pend_ff, pend_in;
   logic [CODE_WIDTH-1:0]  part_ff, part_in;
   logic [ERR_WIDTH-1:0]   err_ff, err_in;
   logic                   fault_ff, fault_in;
   logic                   emo_ff, emo_in;
   logic [COUNT_WIDTH-1:0] char_ff, char_in;
   logic [COUNT_WIDTH-1:0] kana_ff, kana_in;
   logic [COUNT_WIDTH-1:0] kanji_ff, kanji_in;
   logic [COUNT_WIDTH-1:0] alnum_ff, alnum_in;
   logic [MARK_WIDTH-1:0]  marks_ff [NUM_MARKS];
   logic [MARK_WIDTH-1:0]  marks_in [NUM_MARKS];
   logic [TOKEN_WIDTH-1:0] tok_ff, tok_in;
   logic                   spk_ff, spk_in;
   logic [DIV_DEN_WIDTH-1:0] den_ff, den_in;

   // Result register
   logic [FEAT_WIDTH-1:0]  idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [ERR_WIDTH-1:0]   code_ff, code_in;
   logic                   last_ff, last_in;

   logic [BYTE_WIDTH-1:0]  text_byte;
   logic [COUNT_WIDTH-1:0] chars_v;

   assign text_byte = req_tdata[7:0];
   assign chars_v   = (char_ff == '0) ? COUNT_WIDTH'(1) : char_ff;

   // Decode one byte and update the tallies
   always_comb begin
      logic [1:0]            pend_dec;
      logic                  code_take;
      logic [CODE_WIDTH-1:0] c;
      logic                  skip;
      logic                  is_single;
      logic                  is_prefix;
      pend_in  = pend_ff;
      part_in  = part_ff;
      err_in   = err_ff;
      fault_in = fault_ff;
      emo_in   = emo_ff;
      char_in  = char_ff;
      kana_in  = kana_ff;
      kanji_in = kanji_ff;
      alnum_in = alnum_ff;
      marks_in = marks_ff;
      tok_in   = tok_ff;
      spk_in   = spk_ff;
      code_take = 1'b0;
      c         = '0;
      skip      = 1'b0;
      is_single = 1'b0;
      is_prefix = 1'b0;
      pend_dec  = (pend_ff != 2'd0) ? pend_ff - 2'd1 : 2'd0;
      if (cmd.clear) begin
         pend_in  = '0;
         part_in  = '0;
         err_in   = ERR_NONE;
         fault_in = 1'b0;
         emo_in   = 1'b0;
         char_in  = '0;
         kana_in  = '0;
         kanji_in = '0;
         alnum_in = '0;
         for (int i = 0; i < NUM_MARKS; i++) marks_in[i] = '0;
      end else if (cmd.take) begin
         if (req_tlast) begin
            tok_in = req_tdata[23:8];
            spk_in = req_tdata[24];
         end
         if (req_tuser && err_ff == ERR_NONE) begin
            if (fault_ff) begin
               // Count out the rest of a broken sequence
               pend_in = pend_dec;
               if (pend_dec == 2'd0) begin
                  fault_in = 1'b0;
                  err_in   = ERR_CONT;
               end
            end else if (pend_ff == 2'd0) begin
               if (!text_byte[7]) begin
                  code_take = 1'b1;
                  c         = CODE_WIDTH'(text_byte);
               end else if (text_byte[7:5] == 3'b110) begin
                  part_in = CODE_WIDTH'(text_byte[4:0]);
                  pend_in = 2'd1;
               end else if (text_byte[7:4] == 4'b1110) begin
                  part_in = CODE_WIDTH'(text_byte[3:0]);
                  pend_in = 2'd2;
               end else if (text_byte[7:3] == 5'b11110) begin
                  part_in = CODE_WIDTH'(text_byte[2:0]);
                  pend_in = 2'd3;
               end else begin
                  err_in = ERR_LEAD;
               end
            end else begin
               pend_in = pend_dec;
               if (text_byte[7:6] != 2'b10) begin
                  if (pend_dec == 2'd0) err_in = ERR_CONT;
                  else fault_in = 1'b1;
               end else begin
                  part_in = {part_ff[CODE_WIDTH-7:0], text_byte[5:0]};
                  if (pend_dec == 2'd0) begin
                     code_take = 1'b1;
                     c         = part_in;
                  end
               end
            end
         end
         if (code_take) begin
            char_in = sat_inc(char_ff);
            if (c >= 21'h3040 && c <= 21'h30FF) kana_in = sat_inc(kana_ff);
            if ((c >= 21'h3400 && c <= 21'h4DBF) || (c >= 21'h4E00 && c <= 21'h9FFF) ||
                (c >= 21'hF900 && c <= 21'hFAFF) || (c >= 21'h20000 && c <= 21'h2FA1F))
               kanji_in = sat_inc(kanji_ff);
            if ((c >= 21'h30 && c <= 21'h39) || (c >= 21'h41 && c <= 21'h5A) ||
                (c >= 21'h61 && c <= 21'h7A))
               alnum_in = sat_inc(alnum_ff);
            if (c == 21'h3002 || c == 21'h2E)
               marks_in[MARK_PERIOD] = mark_inc(marks_ff[MARK_PERIOD]);
            if (c == 21'h3001 || c == 21'h2C)
               marks_in[MARK_COMMA] = mark_inc(marks_ff[MARK_COMMA]);
            if (c == 21'h30FC)
               marks_in[MARK_LONG] = mark_inc(marks_ff[MARK_LONG]);
            if (c == 21'h2026)
               marks_in[MARK_ELLIP] = mark_inc(marks_ff[MARK_ELLIP]);
            if (c == 21'hFF01 || c == 21'h21)
               marks_in[MARK_EXCL] = mark_inc(marks_ff[MARK_EXCL]);
            if (c == 21'hFF1F || c == 21'h3F)
               marks_in[MARK_QUEST] = mark_inc(marks_ff[MARK_QUEST]);
            for (int i = 0; i < 51; i++) begin
               if (c == EMOJI_SINGLE[i]) is_single = 1'b1;
            end
            for (int i = 0; i < 4; i++) begin
               if (c == EMOJI_PREFIX[i]) is_prefix = 1'b1;
            end
            // A prefix emoji counts only when the variation selector follows
            if (emo_ff) begin
               emo_in = 1'b0;
               if (c == 21'hFE0F) begin
                  marks_in[MARK_EMOJI] = mark_inc(marks_ff[MARK_EMOJI]);
                  skip = 1'b1;
               end
            end
            if (!skip) begin
               if (is_prefix) emo_in = 1'b1;
               else if (is_single) marks_in[MARK_EMOJI] = mark_inc(marks_ff[MARK_EMOJI]);
            end
         end
      end
   end

   // Log operands: capped count plus one, and cap plus one
   logic [2:0]              mark_sel;
   logic [MARK_WIDTH-1:0]   mcap;
   logic [MARK_WIDTH-1:0]   mval;
   logic [LOG_IN_WIDTH-1:0] lcap;
   logic [LOG_IN_WIDTH-1:0] ln;
   logic [LOG_IN_WIDTH-1:0] log_x;
   logic                    log_done;
   logic [LOG_RES_WIDTH-1:0] log_res;

   assign mark_sel = 3'(cmd.feat - FEAT_MARK0);
   assign mcap     = mark_cap(mark_sel);
   assign mval     = marks_ff[mark_sel];

   always_comb begin
      if (cmd.feat == FEAT_CHARS) begin
         lcap = LOG_IN_WIDTH'(NAME_CAP);
         ln   = (chars_v > COUNT_WIDTH'(NAME_CAP)) ? lcap : LOG_IN_WIDTH'(chars_v);
      end else begin
         lcap = LOG_IN_WIDTH'(mcap);
         ln   = (mval > mcap) ? lcap : LOG_IN_WIDTH'(mval);
      end
      log_x = cmd.log_num ? ln + LOG_IN_WIDTH'(1) : lcap + LOG_IN_WIDTH'(1);
   end

   utfc_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   // Divide operands
   logic [CAP_WIDTH-1:0]     capx;
   logic [TOKEN_WIDTH-1:0]   tok_min;
   logic [RNUM_WIDTH-1:0]    rnum;
   logic [DIV_DEN_WIDTH-1:0] rden;
   logic [DIV_NUM_WIDTH-1:0] dividend;
   logic [DIV_DEN_WIDTH-1:0] divisor;
   logic                     div_done;
   logic [DIV_NUM_WIDTH-1:0] quot;
   logic [DIV_NUM_WIDTH-1:0] quot_log;
   feat_kind_type            kind;

   assign kind    = feat_kind(cmd.feat);
   assign capx    = (token_cap == '0) ? CAP_WIDTH'(1) : token_cap;
   assign tok_min = (tok_ff < capx) ? tok_ff : capx;

   always_comb begin
      case (cmd.feat)
         FEAT_TOKEN: begin
            rnum = RNUM_WIDTH'(tok_min);
            rden = DIV_DEN_WIDTH'(capx);
         end
         FEAT_KANA: begin
            rnum = RNUM_WIDTH'(kana_ff);
            rden = DIV_DEN_WIDTH'(chars_v);
         end
         FEAT_KANJI: begin
            rnum = RNUM_WIDTH'(kanji_ff);
            rden = DIV_DEN_WIDTH'(chars_v);
         end
         FEAT_ALNUM: begin
            rnum = RNUM_WIDTH'(alnum_ff);
            rden = DIV_DEN_WIDTH'(chars_v);
         end
         default: begin
            rnum = RNUM_WIDTH'(tok_ff);
            rden = DIV_DEN_WIDTH'(chars_v);
         end
      endcase
      if (kind == FK_LOG) begin
         dividend = DIV_NUM_WIDTH'(log_res) << QUOT_SHIFT;
         divisor  = den_ff;
      end else begin
         dividend = DIV_NUM_WIDTH'(rnum) << FRAC_BITS;
         divisor  = rden;
      end
   end

   utfc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quot)
   );

   assign quot_log = quot >> (QUOT_SHIFT - FRAC_BITS);
   assign den_in   = cmd.den_latch ? DIV_DEN_WIDTH'(log_res) : den_ff;

   // Load the result register
   always_comb begin
      idx_in  = idx_ff;
      val_in  = val_ff;
      code_in = code_ff;
      last_in = last_ff;
      if (cmd.out_err) begin
         idx_in  = '0;
         val_in  = '0;
         code_in = (err_ff != ERR_NONE) ? err_ff : ERR_TRUNC;
         last_in = 1'b1;
      end else if (cmd.out_load) begin
         idx_in  = cmd.feat;
         code_in = ERR_NONE;
         last_in = (cmd.feat == FEAT_SPEAKER);
         case (kind)
            FK_FLAG:  val_in = spk_ff ? FEAT_ONE : '0;
            FK_LOG:   val_in = quot_log[VALUE_WIDTH-1:0];
            default:  val_in = (|quot[DIV_NUM_WIDTH-1:VALUE_WIDTH]) ? '1
                                                                   : quot[VALUE_WIDTH-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         part_ff  <= '0;
         err_ff   <= ERR_NONE;
         fault_ff <= 1'b0;
         emo_ff   <= 1'b0;
         char_ff  <= '0;
         kana_ff  <= '0;
         kanji_ff <= '0;
         alnum_ff <= '0;
         for (int i = 0; i < NUM_MARKS; i++) marks_ff[i] <= '0;
      end else begin
         pend_ff  <= pend_in;
         part_ff  <= part_in;
         err_ff   <= err_in;
         fault_ff <= fault_in;
         emo_ff   <= emo_in;
         char_ff  <= char_in;
         kana_ff  <= kana_in;
         kanji_ff <= kanji_in;
         alnum_ff <= alnum_in;
         marks_ff <= marks_in;
      end
      tok_ff  <= tok_in;
      spk_ff  <= spk_in;
      den_ff  <= den_in;
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      code_ff <= code_in;
      last_ff <= last_in;
   end

   assign status.text_bad = (err_ff != ERR_NONE) || (pend_ff != 2'd0) || fault_ff;
   assign status.log_done = log_done;
   assign status.div_done = div_done;
   assign status.out_last = last_ff;

   assign rsp_tdata = {4'b0, val_ff, idx_ff};
   assign rsp_tuser = code_ff;
   assign rsp_tlast = last_ff;

endmodule

[hw/rtl/utfc_ctrl.sv]
// Controller: takes text beats, then sequences the feature computations
// and the result handshake. Depends on utfc_pkg.
module utfc_ctrl import utfc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  logic            req_tlast,
   input  logic            rsp_tready,
   input  utfc_status_type status,
   output logic            req_tready,
   output logic            rsp_tvalid,
   output utfc_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic [FEAT_WIDTH-1:0] feat_ff, feat_in;
   feat_kind_type kind;

   assign kind = feat_kind(feat_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tlast) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.text_bad ? ST_RESULT : ST_FEATURE;
         end
         ST_FEATURE: begin
            case (kind)
               FK_FLAG:  state_in = ST_RESULT;
               FK_LOG:   state_in = ST_LOG_DEN;
               default:  state_in = ST_DIVIDE;
            endcase
         end
         ST_LOG_DEN: begin
            if (status.log_done) state_in = ST_LOG_NUM;
         end
         ST_LOG_NUM: begin
            if (status.log_done) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_tready) state_in = status.out_last ? ST_IDLE : ST_FEATURE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and commands
   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      feat_in       = feat_ff;
      cmd           = '0;
      cmd.feat      = feat_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         ST_CHECK: begin
            feat_in     = '0;
            cmd.out_err = status.text_bad;
         end
         ST_FEATURE: begin
            case (kind)
               FK_FLAG:  cmd.out_load  = 1'b1;
               FK_LOG:   cmd.log_start = 1'b1;
               default:  cmd.div_start = 1'b1;
            endcase
         end
         ST_LOG_DEN: begin
            if (status.log_done) begin
               cmd.den_latch = 1'b1;
               cmd.log_start = 1'b1;
               cmd.log_num   = 1'b1;
            end
         end
         ST_LOG_NUM: begin
            cmd.div_start = status.log_done;
         end
         ST_DIVIDE: begin
            cmd.out_load = status.div_done;
         end
         ST_RESULT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (status.out_last) cmd.clear = 1'b1;
               else feat_in = feat_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         feat_ff  <= '0;
      end else begin
         state_ff <= state_in;
         feat_ff  <= feat_in;
      end
   end

endmodule

[hw/rtl/utf8_text_feature_counter.sv]
// UTF-8 text feature counter, top level: register port, controller, datapath.
// Text beats are taken one per cycle while idle, not from end of text until the last
// result is taken. After end of text: 14 results; a log feature takes issue, two log
// runs, a divide and a result beat, a ratio issue, divide and result, the speaker flag
// issue and result, each stretched by rsp_tready stalls. An error text gives one result.
// Reset is synchronous, active high: clears all tallies, cap register to 256.
module utf8_text_feature_counter import utfc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,   // text_byte, token_total, speaker_given
   input  logic                      req_tuser,   // byte_present
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [39:0]               rsp_tdata,   // feature_index, feature_value
   output logic [1:0]                rsp_tuser,   // error_code
   output logic                      rsp_tlast,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [CAP_WIDTH-1:0] cap_ff, cap_in;
   logic                 csr_write;
   utfc_cmd_type         cmd;
   utfc_status_type      status;

   // Register write on the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_TOKEN_CAP);
   assign cap_in     = csr_write ? csr_pwdata[CAP_WIDTH-1:0] : cap_ff;
   assign csr_prdata = (csr_paddr[2] == REG_TOKEN_CAP) ? CSR_DATA_WIDTH'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= CAP_RESET;
      else cap_ff <= cap_in;
   end

   utfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   utfc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .token_cap (cap_ff),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

[tb/sv/utf8_text_feature_counter_test.sv]
// Self-checking bench for the UTF-8 text feature counter: streams texts,
// predicts the 14-feature vectors or error beats, and checks every result.
// Depends on utfc_pkg and the utf8_text_feature_counter RTL.
`timescale 1ns / 1ps

// Predicts the feature vector of each text and holds the beats still due
class feature_scoreboard;
   typedef struct {
      logic [3:0]  idx;
      logic [31:0] value;
      logic [1:0]  err;
      logic        last;
   } feature_beat_type;

   feature_beat_type due_q[$];
   int unsigned mismatches;
   int unsigned checked;
   int unsigned error_texts;
   int unsigned good_texts;

   // Copy of the block's per-text state
   logic [15:0] cap_reg;
   int unsigned pending;
   logic [20:0] code;
   longint unsigned chars, kana, kanji, alnum;
   int unsigned marks[7];
   bit          emoji_wait;
   logic [1:0]  err_flag;
   bit          fault;

   function new();
      cap_reg = utfc_pkg::CAP_RESET;
      clear_text();
   endfunction

   function void clear_text();
      pending = 0; code = 0; chars = 0; kana = 0; kanji = 0; alnum = 0;
      foreach (marks[i]) marks[i] = 0;
      emoji_wait = 0; err_flag = utfc_pkg::ERR_NONE; fault = 0;
   endfunction

   function void bump(ref longint unsigned c);
      if (c < (64'd1 << utfc_pkg::COUNT_WIDTH) - 1) c++;
   endfunction

   function void bump_mark(int i);
      if (marks[i] < 31) marks[i]++;
   endfunction

   function bit is_emoji_single(logic [20:0] c);
      case (c)
         21'h23E9, 21'h1F36D, 21'h1F3AD, 21'h1F3B5, 21'h1F422, 21'h1F431, 21'h1F442,
         21'h1F443, 21'h1F445, 21'h1F44C, 21'h1F44F, 21'h1F48B, 21'h1F4A5, 21'h1F4A6,
         21'h1F4AA, 21'h1F4C4, 21'h1F4DE, 21'h1F4E2, 21'h1F4E3, 21'h1F606, 21'h1F60A,
         21'h1F60C, 21'h1F60E, 21'h1F60F, 21'h1F612, 21'h1F616, 21'h1F61F, 21'h1F620,
         21'h1F62A, 21'h1F62D, 21'h1F62E, 21'h1F630, 21'h1F631, 21'h1F632, 21'h1F634,
         21'h1F644, 21'h1F64F, 21'h1F910, 21'h1F914, 21'h1F922, 21'h1F927, 21'h1F92D,
         21'h1F964, 21'h1F971, 21'h1F974, 21'h1F975, 21'h1F979, 21'h1F97A, 21'h1FAE3,
         21'h1FAF6, 21'h1F4D6: return 1;
         default: return 0;
      endcase
   endfunction

   function void count_code(logic [20:0] c);
      bump(chars);
      if (c >= 21'h3040 && c <= 21'h30FF) bump(kana);
      if ((c >= 21'h3400 && c <= 21'h4DBF) || (c >= 21'h4E00 && c <= 21'h9FFF) ||
          (c >= 21'hF900 && c <= 21'hFAFF) || (c >= 21'h20000 && c <= 21'h2FA1F))
         bump(kanji);
      if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
         bump(alnum);
      if (c == 21'h3002 || c == ".") bump_mark(0);
      if (c == 21'h3001 || c == ",") bump_mark(1);
      if (c == 21'h30FC) bump_mark(2);
      if (c == 21'h2026) bump_mark(3);
      if (c == 21'hFF01 || c == "!") bump_mark(4);
      if (c == 21'hFF1F || c == "?") bump_mark(5);
      if (emoji_wait) begin
         emoji_wait = 0;
         if (c == 21'hFE0F) begin
            bump_mark(6);
            return;
         end
      end
      if (c == 21'h23F1 || c == 21'h23F8 || c == 21'h1F32C || c == 21'h1F39B)
         emoji_wait = 1;
      else if (is_emoji_single(c)) bump_mark(6);
   endfunction

   function void decode_byte(logic [7:0] b);
      if (err_flag != utfc_pkg::ERR_NONE) return;
      if (fault) begin
         if (pending > 0) pending--;
         if (pending == 0) begin
            fault = 0; err_flag = utfc_pkg::ERR_CONT;
         end
         return;
      end
      if (pending == 0) begin
         if (b[7] == 1'b0) count_code({13'd0, b});
         else if (b[7:5] == 3'b110) begin code = b[4:0]; pending = 1; end
         else if (b[7:4] == 4'b1110) begin code = b[3:0]; pending = 2; end
         else if (b[7:3] == 5'b11110) begin code = b[2:0]; pending = 3; end
         else err_flag = utfc_pkg::ERR_LEAD;
         return;
      end
      pending--;
      if (b[7:6] != 2'b10) begin
         if (pending == 0) err_flag = utfc_pkg::ERR_CONT;
         else fault = 1;
         return;
      end
      code = {code[14:0], b[5:0]};
      if (pending == 0) count_code(code);
   endfunction

   // log2 with 28 fraction bits, bit-serial squaring, truncated
   function longint unsigned log2_q28(longint unsigned x);
      longint unsigned e, m, frac, bitv;
      e = 0; frac = 0;
      while (e < 31 && (x >> (e + 1)) != 0) e++;
      m = (e <= 28) ? (x << (28 - e)) : (x >> (e - 28));
      for (bitv = 64'd1 << 27; bitv != 0; bitv >>= 1) begin
         m = (m * m) >> 28;
         if (m >= (64'd1 << 29)) begin m >>= 1; frac |= bitv; end
      end
      return (e << 28) | frac;
   endfunction

   function longint unsigned log_share(longint unsigned n, longint unsigned c);
      longint unsigned den;
      den = log2_q28(c + 1);
      if (n > c) n = c;
      if (den == 0) return 0;
      return ((log2_q28(n + 1) << 30) / den) >> (30 - utfc_pkg::FRAC_BITS);
   endfunction

   function longint unsigned share(longint unsigned num, longint unsigned den);
      longint unsigned q;
      q = (num << utfc_pkg::FRAC_BITS) / den;
      return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
   endfunction

   function void push(int idx, longint unsigned v, logic [1:0] err, bit last);
      feature_beat_type r;
      r.idx = idx; r.value = v[31:0]; r.err = err; r.last = last;
      due_q.push_back(r);
   endfunction

   // Note one accepted input beat and queue the results it causes
   function void note_beat(logic [7:0] b, bit present, bit eot, logic [15:0] tok, bit spk);
      longint unsigned f[14];
      longint unsigned c, n;
      int unsigned mark_cap[7];
      mark_cap = '{8, 16, 8, 8, 8, 8, 8};
      if (present) decode_byte(b);
      if (!eot) return;
      if (err_flag != utfc_pkg::ERR_NONE || pending != 0 || fault) begin
         push(utfc_pkg::FEAT_TOKEN, 0,
              (err_flag != utfc_pkg::ERR_NONE) ? err_flag : utfc_pkg::ERR_TRUNC, 1);
         error_texts++;
         clear_text();
         return;
      end
      c = (cap_reg == 0) ? 1 : cap_reg;
      n = (chars == 0) ? 1 : chars;
      f[0] = share((tok < c) ? tok : c, c);
      f[1] = log_share(n, utfc_pkg::NAME_CAP);
      f[2] = share(tok, n);
      for (int k = 0; k < 7; k++) f[3 + k] = log_share(marks[k], mark_cap[k]);
      f[10] = share(kana, n);
      f[11] = share(kanji, n);
      f[12] = share(alnum, n);
      f[13] = spk ? (64'd1 << utfc_pkg::FRAC_BITS) : 0;
      for (int k = 0; k < 14; k++) push(k, f[k], utfc_pkg::ERR_NONE, k == 13);
      good_texts++;
      clear_text();
   endfunction

   // Compare one result beat with the oldest prediction
   function void check_result(logic [3:0] idx, logic [31:0] v, logic [1:0] err, bit last);
      feature_beat_type r;
      checked++;
      if (due_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected result idx=%0d value=%h err=%0d last=%0b",
                     idx, v, err, last);
         return;
      end
      r = due_q.pop_front();
      if (idx !== r.idx || v !== r.value || err !== r.err || last !== r.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: expected idx=%0d value=%h err=%0d last=%0b, got %0d %h %0d %0b",
                     r.idx, r.value, r.err, r.last, idx, v, err, last);
      end
   endfunction
endclass

module utf8_text_feature_counter_test;
   import utfc_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // text_byte, token_total, speaker_given
   logic        req_tuser;   // byte_present
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // feature_index, feature_value
   logic [1:0]  rsp_tuser;   // error_code
   logic        rsp_tlast;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic        csr_pready;

   feature_scoreboard board;
   bit          quiet_tail;
   bit          hold_off;
   int unsigned beats_sent;
   logic [7:0]  text_q[$];

   utf8_text_feature_counter DUT (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_beat(req_tdata[7:0], req_tuser, req_tlast, req_tdata[23:8],
                            req_tdata[24]);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata[3:0], rsp_tdata[35:4], rsp_tuser, rsp_tlast);
      end
   end

   // Result receiver: random stall bursts, one long hold-off, none at the tail
   initial begin
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp_tready <= 1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // Drive one input beat and hold it until taken
   task automatic send_beat(logic [7:0] b, bit present, bit eot, logic [15:0] tok, bit spk);
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {7'd0, spk, tok, b};
      req_tuser  <= present;
      req_tlast  <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   // Append the UTF-8 form of a code point to the text
   task automatic add_code(logic [20:0] c);
      if (c < 21'h80) text_q.push_back(c[7:0]);
      else if (c < 21'h800) begin
         text_q.push_back({3'b110, c[10:6]});
         text_q.push_back({2'b10, c[5:0]});
      end else if (c < 21'h10000) begin
         text_q.push_back({4'b1110, c[15:12]});
         text_q.push_back({2'b10, c[11:6]});
         text_q.push_back({2'b10, c[5:0]});
      end else begin
         text_q.push_back({5'b11110, c[20:18]});
         text_q.push_back({2'b10, c[17:12]});
         text_q.push_back({2'b10, c[11:6]});
         text_q.push_back({2'b10, c[5:0]});
      end
   endtask

   // Stream the text; end on its last byte or on a bare end beat
   task automatic send_text(logic [15:0] tok, bit spk, bit bare_end);
      int n;
      n = text_q.size();
      if (n == 0) bare_end = 1;
      for (int i = 0; i < n; i++)
         send_beat(text_q[i], 1, !bare_end && i == n - 1, tok, spk);
      if (bare_end) send_beat($urandom, 0, 1, tok, spk);
      text_q.delete();
   endtask

   function automatic logic [20:0] pick_code();
      logic [20:0] pool[24];
      pool = '{"a", "Z", "5", ".", ",", "!", "?", " ", 21'h3002, 21'h3001, 21'h30FC,
               21'h2026, 21'hFF01, 21'hFF1F, 21'h3042, 21'h30A2, 21'h4E00, 21'h9FFF,
               21'h3400, 21'hF900, 21'h20000, 21'h2FA1F, 21'h1F62E, 21'h23E9};
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 127);
         1: return $urandom_range(0, 21'h1FFFFF);
         2: return $urandom_range(21'h80, 21'hFFFF);
         default: return pool[$urandom_range(0, 23)];
      endcase
   endfunction

   task automatic random_text();
      int n;
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 7))
            0: begin add_code(21'h23F1 + 7 * $urandom_range(0, 1)); add_code(21'hFE0F); end
            1: begin add_code(21'h1F62E); add_code(21'h200D); add_code(21'h1F4A8); end
            2: add_code(21'h1F32C + 111 * $urandom_range(0, 1));
            default: add_code(pick_code());
         endcase
      end
      // Occasionally push a mark tally past saturation
      if ($urandom_range(0, 15) == 0) repeat (34) add_code(".");
   endtask

   // Well-formed start, then one broken sequence
   task automatic broken_text();
      if ($urandom_range(0, 1)) add_code(pick_code());
      case ($urandom_range(0, 3))
         0: text_q.push_back($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hBF)
                                                  : $urandom_range(8'hF8, 8'hFF));
         1: begin
            text_q.push_back($urandom_range(8'hE0, 8'hEF));
            text_q.push_back($urandom_range(0, 8'h7F));
            if ($urandom_range(0, 1)) text_q.push_back($urandom);
         end
         2: begin
            text_q.push_back($urandom_range(8'hF0, 8'hF7));
            repeat ($urandom_range(0, 2)) text_q.push_back($urandom_range(8'h80, 8'hBF));
         end
         default: text_q.push_back($urandom_range(8'hC0, 8'hDF));
      endcase
      repeat ($urandom_range(0, 3)) text_q.push_back($urandom);
   endtask

   task automatic wait_drained();
      while (board.due_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Register write: setup beat, then access beat
   task automatic write_cap(logic [15:0] v);
      wait_drained();
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= CSR_ADDR_WIDTH'(REG_TOKEN_CAP) << 2; csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.cap_reg = v;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   initial begin
      logic [15:0] caps[4];
      board = new();
      reset = 1; req_tvalid = 0; req_tdata = 0; req_tuser = 0; req_tlast = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      quiet_tail = 0; hold_off = 0; beats_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: empty text, ASCII marks, Japanese text, emoji forms, errors
      send_text(16'hFFFF, 1, 1);
      add_code("a"); add_code("."); add_code(","); add_code("!"); add_code("?");
      send_text(16'd0, 0, 0);
      add_code(21'h3042); add_code(21'h4E00); add_code(21'h3002); add_code(21'h30FC);
      send_text(16'd300, 1, 1);
      add_code(21'h23F1); add_code(21'hFE0F); add_code(21'h1F62E); add_code(21'h200D);
      send_text(16'd7, 0, 0);
      text_q.push_back(8'hFF);
      send_text(16'd1, 0, 1);
      text_q.push_back(8'hE3); text_q.push_back(8'h41); text_q.push_back(8'h80);
      send_text(16'd1, 0, 0);
      text_q.push_back(8'hF0); text_q.push_back(8'h9F);
      send_text(16'd1, 0, 1);
      send_beat(8'h00, 0, 0, 16'd0, 0);
      drop_valid();

      // Random phases over several cap settings
      caps = '{16'd1, 16'd65535, 16'd256, 16'd0};
      foreach (caps[p]) begin
         write_cap((p == 3) ? 16'($urandom_range(2, 65534)) : caps[p]);
         if (p == 1) hold_off = 1;
         if (p == 3) quiet_tail = 1;
         while (beats_sent < 80 * (p + 1) + 20) begin
            case ($urandom_range(0, 9))
               0: broken_text();
               1: begin
                  send_beat($urandom, 0, 0, $urandom, $urandom);
                  continue;
               end
               default: random_text();
            endcase
            send_text($urandom, $urandom, $urandom_range(0, 1));
         end
         drop_valid();
      end

      wait_drained();
      repeat (50) @(posedge clock);
      $display("Covered %0d input beats, %0d full feature vectors, %0d error texts,",
               beats_sent, board.good_texts, board.error_texts);
      $display("%0d result beats checked across four cap settings.", board.checked);
      if (board.mismatches == 0 && board.due_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
